// ===== rtl/hvd_pkg.sv =====
package hvd_pkg;

    // Port field widths.
    localparam int LAT_W  = 28;
    localparam int LON_W  = 29;
    localparam int RAD_W  = 23;
    localparam int DIST_W = 25;

    // Internal widths.
    localparam int ANG_W  = 30;   // angle in half-microdegrees
    localparam int RED_W  = 31;   // angle after wrap into one turn
    localparam int MAG_W  = 28;   // folded angle magnitude
    localparam int N_W    = 59;   // magnitude times the radian factor numerator
    localparam int Z_W    = 32;   // Q30 radians into the rotator
    localparam int CW     = 34;   // CORDIC datapath
    localparam int SC_W   = 32;   // Q30 sine and cosine
    localparam int SQ_W   = 64;   // square root radicand
    localparam int ROOT_W = 32;
    localparam int H_W    = 31;   // clamped haversine term
    localparam int TH_W   = 32;   // clamped central angle

    localparam int SQRT_STEPS   = 32;
    localparam int ATAN_ENTRIES = 40;

    localparam logic signed [RED_W-1:0] TURN_HALF_UDEG    = 31'sd720000000;
    localparam logic signed [RED_W-1:0] HALF_HALF_UDEG    = 31'sd360000000;
    localparam logic signed [RED_W-1:0] QUARTER_HALF_UDEG = 31'sd180000000;

    // Q30 radians = angle * PI_Q31 / 720e6, reduced to angle * K_NUM / K_DEN.
    localparam logic [30:0] K_NUM = 31'd1686629713;
    localparam logic [27:0] K_DEN = 28'd180000000;
    // floor(2^59 / K_DEN), the reciprocal used for the quotient estimate.
    localparam logic [31:0] K_RECIP = 32'((64'd1 << 59) / 64'd180000000);

    localparam logic signed [CW-1:0] GAIN_INV = 34'sd652032874;
    localparam logic [H_W-1:0]       ONE_Q30  = 31'd1073741824;
    localparam logic [TH_W-1:0]      PI_Q30   = 32'd3373259426;
    localparam logic [RAD_W-1:0]     RADIUS_RST = 23'd6378137;

    localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
        32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149,
        32'd1048575,   32'd524287,    32'd262143,    32'd131071,    32'd65535,
        32'd32767,     32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127,       32'd63,
        32'd31,        32'd15,        32'd7,         32'd3,         32'd1,
        32'd0,         32'd0,         32'd0,         32'd0,         32'd0,
        32'd0,         32'd0,         32'd0,         32'd0,         32'd0
    };

    typedef struct packed {
        logic signed [SC_W-1:0] sin_q30;
        logic signed [SC_W-1:0] cos_q30;
    } t_sincos;

endpackage

// ===== rtl/hvd_angle.sv =====
module hvd_angle import hvd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [ANG_W-1:0] i_angle,
    output logic                    o_valid,
    output logic signed [Z_W-1:0]   o_z,
    output logic                    o_neg_cos
);

    localparam int NST = 6;

    logic [NST-1:0] r_vld;

    logic signed [RED_W-1:0] r1_v;
    logic [MAG_W-1:0]        r2_mag;
    logic                    r2_sgn, r2_neg;
    logic [N_W-1:0]          r3_n;
    logic                    r3_sgn, r3_neg;
    logic [N_W-1:0]          r4_n;
    logic [31:0]             r4_q0;
    logic                    r4_sgn, r4_neg;
    logic [N_W-1:0]          r5_n;
    logic [31:0]             r5_q0;
    logic [N_W:0]            r5_p;
    logic                    r5_sgn, r5_neg;
    logic signed [Z_W-1:0]   r6_z;
    logic                    r6_neg;

    logic signed [RED_W-1:0] n1_v, ext, fold;
    logic                    n2_neg;
    logic [63:0]             prod4;
    logic [N_W:0]            rem;
    logic [31:0]             q;

    always_comb begin
        ext = RED_W'(i_angle);
        if (ext >= HALF_HALF_UDEG) begin
            n1_v = ext - TURN_HALF_UDEG;
        end else if (ext < -HALF_HALF_UDEG) begin
            n1_v = ext + TURN_HALF_UDEG;
        end else begin
            n1_v = ext;
        end
    end

    // Fold into a quarter turn; the cosine changes sign when folded.
    always_comb begin
        if (r1_v > QUARTER_HALF_UDEG) begin
            fold   = HALF_HALF_UDEG - r1_v;
            n2_neg = 1'b1;
        end else if (r1_v < -QUARTER_HALF_UDEG) begin
            fold   = -HALF_HALF_UDEG - r1_v;
            n2_neg = 1'b1;
        end else begin
            fold   = r1_v;
            n2_neg = 1'b0;
        end
    end

    assign prod4 = 64'(r3_n[N_W-1:N_W-32]) * 64'(K_RECIP);

    // The estimate is low by at most two.
    always_comb begin
        rem = {1'b0, r5_n} - r5_p;
        q   = r5_q0 + 32'(rem >= (N_W+1)'(K_DEN))
                    + 32'(rem >= (N_W+1)'({K_DEN, 1'b0}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_v   <= n1_v;
            r2_sgn <= fold[RED_W-1];
            r2_mag <= fold[RED_W-1] ? MAG_W'(-fold) : MAG_W'(fold);
            r2_neg <= n2_neg;
            r3_n   <= N_W'(r2_mag) * N_W'(K_NUM);
            r3_sgn <= r2_sgn;
            r3_neg <= r2_neg;
            r4_n   <= r3_n;
            r4_q0  <= prod4[63:32];
            r4_sgn <= r3_sgn;
            r4_neg <= r3_neg;
            r5_n   <= r4_n;
            r5_q0  <= r4_q0;
            r5_p   <= (N_W+1)'(r4_q0) * (N_W+1)'(K_DEN);
            r5_sgn <= r4_sgn;
            r5_neg <= r4_neg;
            r6_z   <= r5_sgn ? -$signed(q) : $signed(q);
            r6_neg <= r5_neg;
        end
    end

    assign o_valid   = r_vld[NST-1];
    assign o_z       = r6_z;
    assign o_neg_cos = r6_neg;

endmodule

// ===== rtl/hvd_rot.sv =====
module hvd_rot import hvd_pkg::*; #(
    parameter int STAGES = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [Z_W-1:0] i_z,
    input  logic                  i_neg_cos,
    output logic                  o_valid,
    output t_sincos               o_sc
);

    logic signed [CW-1:0] r_x [STAGES];
    logic signed [CW-1:0] r_y [STAGES];
    logic signed [CW-1:0] r_z [STAGES];
    logic                 r_neg [STAGES];
    logic                 r_vld [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_st
        logic signed [CW-1:0] x_in, y_in, z_in, x_nx, y_nx, z_nx, atn;
        logic                 neg_in, vld_in;

        if (g == 0) begin : g_first
            assign x_in   = GAIN_INV;
            assign y_in   = '0;
            assign z_in   = CW'(i_z);
            assign neg_in = i_neg_cos;
            assign vld_in = i_valid;
        end else begin : g_next
            assign x_in   = r_x[g-1];
            assign y_in   = r_y[g-1];
            assign z_in   = r_z[g-1];
            assign neg_in = r_neg[g-1];
            assign vld_in = r_vld[g-1];
        end

        assign atn = $signed(CW'(ATAN_TAB[g]));

        always_comb begin
            if (!z_in[CW-1]) begin
                x_nx = x_in - (y_in >>> g);
                y_nx = y_in + (x_in >>> g);
                z_nx = z_in - atn;
            end else begin
                x_nx = x_in + (y_in >>> g);
                y_nx = y_in - (x_in >>> g);
                z_nx = z_in + atn;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                // The last stage applies the cosine sign from the fold.
                if (g == STAGES - 1) begin
                    r_x[g] <= neg_in ? -x_nx : x_nx;
                end else begin
                    r_x[g] <= x_nx;
                end
                r_y[g]   <= y_nx;
                r_z[g]   <= z_nx;
                r_neg[g] <= neg_in;
            end
        end
    end

    assign o_valid      = r_vld[STAGES-1];
    assign o_sc.sin_q30 = SC_W'(r_y[STAGES-1]);
    assign o_sc.cos_q30 = SC_W'(r_x[STAGES-1]);

endmodule

// ===== rtl/hvd_isqrt.sv =====
module hvd_isqrt import hvd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SQ_W-1:0]   i_n,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root
);

    logic [SQ_W-1:0] r_n    [SQRT_STEPS];
    logic [SQ_W-1:0] r_root [SQRT_STEPS];
    logic            r_vld  [SQRT_STEPS];

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_st
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * g);
        logic [SQ_W-1:0] n_in, root_in, t, n_nx, root_nx;
        logic            vld_in;

        if (g == 0) begin : g_first
            assign n_in    = i_n;
            assign root_in = '0;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign n_in    = r_n[g-1];
            assign root_in = r_root[g-1];
            assign vld_in  = r_vld[g-1];
        end

        always_comb begin
            t = root_in + BIT;
            if (n_in >= t) begin
                n_nx    = n_in - t;
                root_nx = (root_in >> 1) + BIT;
            end else begin
                n_nx    = n_in;
                root_nx = root_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[g]    <= n_nx;
                r_root[g] <= root_nx;
            end
        end
    end

    assign o_valid = r_vld[SQRT_STEPS-1];
    assign o_root  = r_root[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

// ===== rtl/hvd_vec.sv =====
module hvd_vec import hvd_pkg::*; #(
    parameter int STAGES = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [SC_W-1:0] i_x,
    input  logic signed [SC_W-1:0] i_y,
    output logic                   o_valid,
    output logic signed [CW-1:0]   o_z
);

    logic signed [CW-1:0] r_x [STAGES];
    logic signed [CW-1:0] r_y [STAGES];
    logic signed [CW-1:0] r_z [STAGES];
    logic                 r_vld [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_st
        logic signed [CW-1:0] x_in, y_in, z_in, x_nx, y_nx, z_nx, atn;
        logic                 vld_in;

        if (g == 0) begin : g_first
            assign x_in   = CW'(i_x);
            assign y_in   = CW'(i_y);
            assign z_in   = '0;
            assign vld_in = i_valid;
        end else begin : g_next
            assign x_in   = r_x[g-1];
            assign y_in   = r_y[g-1];
            assign z_in   = r_z[g-1];
            assign vld_in = r_vld[g-1];
        end

        assign atn = $signed(CW'(ATAN_TAB[g]));

        // Drive y toward zero, summing the rotation angle.
        always_comb begin
            if (!y_in[CW-1]) begin
                x_nx = x_in + (y_in >>> g);
                y_nx = y_in - (x_in >>> g);
                z_nx = z_in + atn;
            end else begin
                x_nx = x_in - (y_in >>> g);
                y_nx = y_in + (x_in >>> g);
                z_nx = z_in - atn;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g] <= x_nx;
                r_y[g] <= y_nx;
                r_z[g] <= z_nx;
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_z     = r_z[STAGES-1];

endmodule

// ===== rtl/haversine_distance.sv =====
// Great-circle distance between two points by the haversine formula.
//
// Input channel: i_valid, o_stall (driven from i_stall) and the four
// coordinates in signed microdegrees. A word is taken at a rising edge with
// i_valid high and o_stall low. Output channel: o_valid, i_stall and
// o_distance_m in whole meters; a word leaves at an edge with o_valid high
// and i_stall low. The user must write the sphere radius via i_cfg_we and
// i_cfg_wdata only while idle (not enforced); reset loads 6378137 meters.
//
// The block is a single pipeline with no feedback, so a new word can enter
// in every cycle unless the pipeline is stalled. Its stages in order: one
// input register, the angle reduction, a rotation CORDIC for the sines and
// cosines, the multiplies for the haversine term, two 32-step square roots
// with registers between them, a vectoring CORDIC for the arcsine, one
// clamp and the final radius multiply. The two square roots make up most
// of the pipeline's depth.
//
// When a result sits in the output register and the receiver stalls, the
// whole pipeline holds and o_stall goes high; nothing is dropped or repeated.
// Reset clears every valid bit, so the pipeline comes up empty.
module haversine_distance import hvd_pkg::*; #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [LAT_W-1:0] i_lat_a,
    input  logic signed [LON_W-1:0] i_lon_a,
    input  logic signed [LAT_W-1:0] i_lat_b,
    input  logic signed [LON_W-1:0] i_lon_b,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [DIST_W-1:0]       o_distance_m,
    input  logic                    i_cfg_we,
    input  logic [RAD_W-1:0]        i_cfg_wdata
);

    // Angle lanes.
    localparam int IDX_DLAT = 0;
    localparam int IDX_DLON = 1;
    localparam int IDX_LATA = 2;
    localparam int IDX_LATB = 3;
    localparam int LANES    = 4;

    logic en;

    logic [RAD_W-1:0]        r_radius;
    logic                    r_in_vld;
    logic signed [ANG_W-1:0] r_ang [LANES];

    logic                    ang_vld [LANES];
    logic signed [Z_W-1:0]   ang_z   [LANES];
    logic                    ang_neg [LANES];
    logic                    rot_vld [LANES];
    t_sincos                 rot_sc  [LANES];

    // Haversine term.
    logic                    r_m1_vld, r_m2_vld, r_m3_vld;
    logic signed [63:0]      r_m1_ss, r_m1_cc, r_m1_oo;
    logic signed [CW-1:0]    r_m2_a;
    logic signed [63:0]      r_m2_m;
    logic [H_W-1:0]          r_h;
    logic signed [SC_W-1:0]  cc_q30, oo_q30;
    logic signed [CW-1:0]    h_sum;

    // Half-angle sine and its cosine.
    logic                    sq1_vld, sq2_vld;
    logic [ROOT_W-1:0]       sq1_root, sq2_root;
    logic                    r_q1_vld, r_q2_vld, r_q3_vld;
    logic [H_W-1:0]          r_q1_s, r_q2_s, r_q3_s;
    logic [2*H_W-1:0]        r_q2_ss;
    logic [SQ_W-1:0]         r_q3_n;
    logic [H_W-1:0]          r_sd [SQRT_STEPS];

    // Central angle and distance.
    logic                    vec_vld;
    logic signed [CW-1:0]    vec_z;
    logic signed [CW:0]      theta2;
    logic                    r_th_vld;
    logic [TH_W-1:0]         r_theta;
    logic [RAD_W+TH_W-1:0]   dist_prod;
    logic                    r_out_vld;
    logic [DIST_W-1:0]       r_dist;

    // The pipeline moves unless a finished word is held by the receiver.
    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (en) begin
            r_in_vld <= i_valid;
        end
    end

    // Angles in half-microdegrees: the differences count twice as half
    // units, and the single latitudes are doubled.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang[IDX_DLAT] <= ANG_W'(i_lat_a) - ANG_W'(i_lat_b);
            r_ang[IDX_DLON] <= ANG_W'(i_lon_a) - ANG_W'(i_lon_b);
            r_ang[IDX_LATA] <= ANG_W'(i_lat_a) <<< 1;
            r_ang[IDX_LATB] <= ANG_W'(i_lat_b) <<< 1;
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        hvd_angle u_angle (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (en),
            .i_valid   (r_in_vld),
            .i_angle   (r_ang[l]),
            .o_valid   (ang_vld[l]),
            .o_z       (ang_z[l]),
            .o_neg_cos (ang_neg[l])
        );

        hvd_rot #(
            .STAGES (CORDIC_STAGES)
        ) u_rot (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (en),
            .i_valid   (ang_vld[l]),
            .i_z       (ang_z[l]),
            .i_neg_cos (ang_neg[l]),
            .o_valid   (rot_vld[l]),
            .o_sc      (rot_sc[l])
        );
    end

    // h = sin^2(dlat/2) + cos(lat_a) cos(lat_b) sin^2(dlon/2), every
    // product truncated back to Q30 with a flooring shift.
    assign cc_q30 = SC_W'(r_m1_cc >>> 30);
    assign oo_q30 = SC_W'(r_m1_oo >>> 30);
    assign h_sum  = r_m2_a + CW'(r_m2_m >>> 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
            r_m3_vld <= 1'b0;
        end else if (en) begin
            r_m1_vld <= rot_vld[IDX_DLAT];
            r_m2_vld <= r_m1_vld;
            r_m3_vld <= r_m2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_ss <= 64'(rot_sc[IDX_DLAT].sin_q30) * 64'(rot_sc[IDX_DLAT].sin_q30);
            r_m1_cc <= 64'(rot_sc[IDX_LATA].cos_q30) * 64'(rot_sc[IDX_LATB].cos_q30);
            r_m1_oo <= 64'(rot_sc[IDX_DLON].sin_q30) * 64'(rot_sc[IDX_DLON].sin_q30);
            r_m2_a  <= CW'(r_m1_ss >>> 30);
            r_m2_m  <= 64'(cc_q30) * 64'(oo_q30);
            if (h_sum[CW-1]) begin
                r_h <= '0;
            end else if (h_sum > $signed(CW'(ONE_Q30))) begin
                r_h <= ONE_Q30;
            end else begin
                r_h <= H_W'(h_sum);
            end
        end
    end

    // s = sqrt(h) in Q30.
    hvd_isqrt u_sqrt_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_m3_vld),
        .i_n     (SQ_W'(r_h) << 30),
        .o_valid (sq1_vld),
        .o_root  (sq1_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_vld <= 1'b0;
            r_q2_vld <= 1'b0;
            r_q3_vld <= 1'b0;
        end else if (en) begin
            r_q1_vld <= sq1_vld;
            r_q2_vld <= r_q1_vld;
            r_q3_vld <= r_q2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q1_s  <= (sq1_root > ROOT_W'(ONE_Q30)) ? ONE_Q30 : H_W'(sq1_root);
            r_q2_s  <= r_q1_s;
            r_q2_ss <= (2*H_W)'(r_q1_s) * (2*H_W)'(r_q1_s);
            r_q3_s  <= r_q2_s;
            r_q3_n  <= (SQ_W'(1) << 60) - SQ_W'(r_q2_ss);
        end
    end

    // c = sqrt(1 - s^2); s rides alongside in a delay line.
    hvd_isqrt u_sqrt_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_q3_vld),
        .i_n     (r_q3_n),
        .o_valid (sq2_vld),
        .o_root  (sq2_root)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= r_q3_s;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    hvd_vec #(
        .STAGES (CORDIC_STAGES)
    ) u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq2_vld),
        .i_x     ($signed(sq2_root)),
        .i_y     ($signed(SC_W'(r_sd[SQRT_STEPS-1]))),
        .o_valid (vec_vld),
        .o_z     (vec_z)
    );

    // theta = 2 asin(s), clamped to [0, pi].
    assign theta2    = {vec_z, 1'b0};
    assign dist_prod = (RAD_W+TH_W)'(r_radius) * (RAD_W+TH_W)'(r_theta);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_th_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_th_vld  <= vec_vld;
            r_out_vld <= r_th_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (theta2[CW]) begin
                r_theta <= '0;
            end else if (theta2 > $signed((CW+1)'(PI_Q30))) begin
                r_theta <= PI_Q30;
            end else begin
                r_theta <= TH_W'(theta2);
            end
            r_dist <= dist_prod[30 +: DIST_W];
        end
    end

    assign o_valid      = r_out_vld;
    assign o_distance_m = r_dist;

    a_angle_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ang_vld[IDX_DLAT] == ang_vld[IDX_DLON]) && (ang_vld[IDX_DLAT] == ang_vld[IDX_LATA])
        && (ang_vld[IDX_DLAT] == ang_vld[IDX_LATB]))
        else $error("angle lanes out of step");

    a_rot_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rot_vld[IDX_DLAT] == rot_vld[IDX_DLON]) && (rot_vld[IDX_DLAT] == rot_vld[IDX_LATA])
        && (rot_vld[IDX_DLAT] == rot_vld[IDX_LATB]))
        else $error("rotator lanes out of step");

    a_h_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m3_vld |-> (r_h <= ONE_Q30))
        else $error("haversine term above one");

    a_theta_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_th_vld |-> (r_theta <= PI_Q30))
        else $error("central angle above pi");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no word held");

endmodule
